// File: design/oaht_pkg.sv
// Shared constants, codes and types for the open-address hash table.
`timescale 1ns / 1ps
package oaht_pkg;

    localparam int SLOTS_DEF   = 1024;
    localparam int KEY_W_DEF   = 64;
    localparam int VAL_W_DEF   = 32;

    localparam int KEY_PORT_W  = 64;
    localparam int VAL_PORT_W  = 32;
    localparam int SLOT_PORT_W = 10;
    localparam int SIZE_W      = 11;
    localparam int LOAD_W      = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int PERCENT     = 100;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd863;
    localparam logic [LOAD_W-1:0] LOAD_RESET = 7'd80;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ACT_FIND        = 2'd0,
        ACT_REPLACE     = 2'd1,
        ACT_REMOVE      = 2'd2,
        ACT_REMOVE_SLOT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } t_tag;

    typedef struct packed {
        logic tag_we;
        logic kv_we;
        t_tag tag;
    } t_wr_ctrl;

endpackage

// File: design/oaht_req_if.sv
// Request channel: action, key, value and slot with valid/ready.
`timescale 1ns / 1ps
interface oaht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] key;
    logic [31:0] value_in;
    logic [9:0]  slot_in;

    modport source (output valid, action, key, value_in, slot_in, input ready);
    modport sink   (input valid, action, key, value_in, slot_in, output ready);
endinterface

// File: design/oaht_rsp_if.sv
// Response channel: found flag, value, slot and status with valid/ready.
`timescale 1ns / 1ps
interface oaht_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] value_out;
    logic [9:0]  slot_out;
    logic        status;

    modport source (output valid, found, value_out, slot_out, status, input ready);
    modport sink   (input valid, found, value_out, slot_out, status, output ready);
endinterface

// File: design/oaht_mod.sv
// Bit-serial restoring remainder unit: key modulo table size, one bit a cycle.
`timescale 1ns / 1ps
module oaht_mod #(
    parameter int KEY_WIDTH = oaht_pkg::KEY_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [KEY_WIDTH-1:0]        i_key,
    input  logic [oaht_pkg::SIZE_W-1:0] i_div,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [oaht_pkg::SIZE_W-1:0] o_rem
);
    localparam int ZW  = oaht_pkg::SIZE_W;
    localparam int CNW = $clog2(KEY_WIDTH + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNW-1:0]  r_cnt, n_cnt;
    logic [KEY_WIDTH-1:0] r_dvd, n_dvd;
    logic [ZW-1:0]   r_div, n_div;
    logic [ZW-1:0]   r_rem, n_rem;
    logic [ZW:0]     shifted;

    // shift in the next dividend bit and subtract once
    assign shifted = {r_rem, r_dvd[KEY_WIDTH-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNW'(KEY_WIDTH);
            n_dvd  = i_key;
            n_div  = i_div;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - 1'b1;
            if (shifted >= {1'b0, r_div}) begin
                n_rem = ZW'(shifted - {1'b0, r_div});
            end else begin
                n_rem = ZW'(shifted);
            end
            if (r_cnt == CNW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: design/oaht_store.sv
// Slot store: key, value and tag memories with registered read and tag clear sweep.
`timescale 1ns / 1ps
module oaht_store #(
    parameter int SLOTS       = oaht_pkg::SLOTS_DEF,
    parameter int KEY_WIDTH   = oaht_pkg::KEY_W_DEF,
    parameter int VALUE_WIDTH = oaht_pkg::VAL_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(SLOTS)-1:0]      i_rd_addr,
    input  logic [$clog2(SLOTS)-1:0]      i_wr_addr,
    input  oaht_pkg::t_wr_ctrl            i_wr,
    input  logic [KEY_WIDTH-1:0]          i_wr_key,
    input  logic [VALUE_WIDTH-1:0]        i_wr_val,
    output oaht_pkg::t_tag                o_rd_tag,
    output logic [KEY_WIDTH-1:0]          o_rd_key,
    output logic [VALUE_WIDTH-1:0]        o_rd_val,
    output logic                          o_clr_done
);
    localparam int SW = $clog2(SLOTS);

    oaht_pkg::t_tag         mem_tag [SLOTS];
    logic [KEY_WIDTH-1:0]   mem_key [SLOTS];
    logic [VALUE_WIDTH-1:0] mem_val [SLOTS];

    logic          r_clr_busy;
    logic [SW-1:0] r_clr_idx;

    // sweep the tag memory to empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == SW'(SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // tag write port, shared by the sweep and the sequencer
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_tag[r_clr_idx] <= oaht_pkg::TAG_EMPTY;
        end else if (i_wr.tag_we) begin
            mem_tag[i_wr_addr] <= i_wr.tag;
        end
    end

    // key and value write
    always_ff @(posedge i_clk) begin
        if (i_wr.kv_we) begin
            mem_key[i_wr_addr] <= i_wr_key;
            mem_val[i_wr_addr] <= i_wr_val;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rd_tag <= mem_tag[i_rd_addr];
        o_rd_key <= mem_key[i_rd_addr];
        o_rd_val <= mem_val[i_rd_addr];
    end

    assign o_clr_done = !r_clr_busy;
endmodule

// File: design/open_address_hash_table_core.sv
// Top level: request sequencer for the quadratic-probing hash table.
// Find and remove by key run the remainder unit for the home slot, then read
//   and check each probed slot; replace first checks the load limit and adds writes.
// Remove by slot checks only the given slot. One request at a time; the remainder unit
//   and the single-port store read set the rate. Results wait in an output register.
// Reset (synchronous, active low) clears the count and registers, then sweeps
//   the tag store empty with the request side not ready.
`timescale 1ns / 1ps
module open_address_hash_table_core #(
    parameter int SLOTS       = oaht_pkg::SLOTS_DEF,
    parameter int KEY_WIDTH   = oaht_pkg::KEY_W_DEF,
    parameter int VALUE_WIDTH = oaht_pkg::VAL_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [oaht_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [oaht_pkg::CFG_DATA_W-1:0] i_cfg_data,
    oaht_req_if.sink                        i_req,
    oaht_rsp_if.source                      o_rsp
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int ZW = oaht_pkg::SIZE_W;
    localparam int LW = oaht_pkg::LOAD_W;
    localparam int VP = oaht_pkg::VAL_PORT_W;
    localparam int PP = oaht_pkg::SLOT_PORT_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_MOD  = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_WR1  = 8'b0010_0000,
        S_WR2  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [ZW-1:0] r_table_size;
    logic [LW-1:0] r_max_load;
    logic [CW-1:0] r_count, n_count;

    oaht_pkg::t_action     r_act, n_act;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [PP-1:0]         r_slot_in, n_slot_in;
    logic                  r_slot_ok, n_slot_ok;

    logic [SW-1:0] r_cur, n_cur;
    logic [SW-1:0] r_home, n_home;
    logic [ZW-1:0] r_up, n_up;
    logic [ZW-1:0] r_down, n_down;
    logic [ZW-1:0] r_i, n_i;
    logic [ZW-1:0] r_k, n_k;
    logic          r_ph_home, n_ph_home;
    logic          r_ph_down, n_ph_down;
    logic          r_has_tomb, n_has_tomb;
    logic [SW-1:0] r_tomb, n_tomb;
    oaht_pkg::t_tag r_home_tag, n_home_tag;
    logic [SW-1:0] r_at, n_at;
    oaht_pkg::t_tag r_at_tag, n_at_tag;
    logic [VALUE_WIDTH-1:0] r_at_val, n_at_val;
    logic          r_hit, n_hit;

    logic          r_found, n_found;
    logic [VP-1:0] r_vout, n_vout;
    logic [PP-1:0] r_sout, n_sout;
    logic          r_status, n_status;

    logic          r_o_valid;
    logic          r_o_found;
    logic [VP-1:0] r_o_vout;
    logic [PP-1:0] r_o_sout;
    logic          r_o_status;

    logic [ZW-1:0]  sz, rounds, inc_next, up_new, down_new;
    logic [ZW:0]    up_sum;
    logic           accept, out_load, stop, kmatch, last;
    logic           load_bad;
    oaht_pkg::t_tag eff_tag;

    logic           div_start, div_busy, div_done;
    logic [ZW-1:0]  div_rem;
    logic [KEY_WIDTH-1:0] div_key;

    oaht_pkg::t_wr_ctrl   wr;
    logic [SW-1:0]        wr_addr;
    oaht_pkg::t_tag       rd_tag;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic                 clr_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= oaht_pkg::SIZE_RESET;
            r_max_load   <= oaht_pkg::LOAD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                oaht_pkg::CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                oaht_pkg::CFG_MAX_LOAD:   r_max_load   <= LW'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // effective size and probe arithmetic
    assign sz       = (32'(r_table_size) > SLOTS) ? ZW'(SLOTS) : r_table_size;
    assign rounds   = (sz - 1'b1) >> 1;
    assign inc_next = r_ph_home ? ZW'(1) : r_i + ZW'(2);
    assign up_sum   = {1'b0, r_up} + {1'b0, inc_next};
    assign up_new   = (up_sum >= {1'b0, sz}) ? ZW'(up_sum - {1'b0, sz}) : ZW'(up_sum);
    assign down_new = (r_down < r_i) ? ZW'({1'b0, r_down} + {1'b0, sz} - {1'b0, r_i})
                                     : r_down - r_i;
    assign kmatch   = (rd_key == r_key);
    assign stop     = (rd_tag == oaht_pkg::TAG_EMPTY) || kmatch;
    assign last     = r_ph_home ? (rounds == '0)
                                : (r_ph_down && (r_k == rounds - 1'b1));
    assign eff_tag  = r_hit ? oaht_pkg::TAG_TOMB : r_at_tag;
    assign load_bad = (sz == '0) ||
                      ((32'(r_count) * 32'(oaht_pkg::PERCENT)) >=
                       ((32'(r_max_load) + 32'd1) * 32'(sz)));

    assign accept   = i_req.valid && i_req.ready;
    assign out_load = (r_state == S_OUT) && (!r_o_valid || o_rsp.ready);
    assign div_key  = (r_state == S_IDLE) ? i_req.key[KEY_WIDTH-1:0] : r_key;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_act      = r_act;
        n_key      = r_key;
        n_val      = r_val;
        n_slot_in  = r_slot_in;
        n_slot_ok  = r_slot_ok;
        n_cur      = r_cur;
        n_home     = r_home;
        n_up       = r_up;
        n_down     = r_down;
        n_i        = r_i;
        n_k        = r_k;
        n_ph_home  = r_ph_home;
        n_ph_down  = r_ph_down;
        n_has_tomb = r_has_tomb;
        n_tomb     = r_tomb;
        n_home_tag = r_home_tag;
        n_at       = r_at;
        n_at_tag   = r_at_tag;
        n_at_val   = r_at_val;
        n_hit      = r_hit;
        n_found    = r_found;
        n_vout     = r_vout;
        n_sout     = r_sout;
        n_status   = r_status;
        div_start  = 1'b0;
        wr         = '{tag_we: 1'b0, kv_we: 1'b0, tag: oaht_pkg::TAG_TOMB};
        wr_addr    = r_at;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act     = oaht_pkg::t_action'(i_req.action);
                    n_key     = i_req.key[KEY_WIDTH-1:0];
                    n_val     = i_req.value_in[VALUE_WIDTH-1:0];
                    n_slot_in = i_req.slot_in;
                    n_found   = 1'b0;
                    n_vout    = '0;
                    n_sout    = '0;
                    n_status  = 1'b0;
                    unique case (oaht_pkg::t_action'(i_req.action))
                        oaht_pkg::ACT_REMOVE_SLOT: begin
                            n_slot_ok = (32'(i_req.slot_in) < SLOTS);
                            n_cur     = SW'(i_req.slot_in);
                            n_state   = S_RD;
                        end
                        oaht_pkg::ACT_REPLACE: begin
                            n_state = S_LOAD;
                        end
                        oaht_pkg::ACT_FIND, oaht_pkg::ACT_REMOVE: begin
                            if (sz == '0) begin
                                n_state = S_OUT;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_MOD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                // refuse the insert over the load limit
                if (load_bad) begin
                    n_status = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (div_done) begin
                    n_up       = div_rem;
                    n_down     = div_rem;
                    n_cur      = SW'(div_rem);
                    n_home     = SW'(div_rem);
                    n_ph_home  = 1'b1;
                    n_ph_down  = 1'b0;
                    n_has_tomb = 1'b0;
                    n_tomb     = '0;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_act == oaht_pkg::ACT_REMOVE_SLOT) begin
                    n_sout = r_slot_in;
                    if (r_slot_ok && rd_tag == oaht_pkg::TAG_LIVE) begin
                        n_found = 1'b1;
                        n_vout  = VP'(rd_val);
                        wr      = '{tag_we: 1'b1, kv_we: 1'b0, tag: oaht_pkg::TAG_TOMB};
                        wr_addr = r_cur;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    n_state = S_OUT;
                end else if (stop) begin
                    n_at     = r_cur;
                    n_at_tag = rd_tag;
                    n_at_val = rd_val;
                    n_hit    = (rd_tag == oaht_pkg::TAG_LIVE) && kmatch;
                    n_state  = S_WR1;
                end else begin
                    // note the first tombstone in probe order
                    if (!r_has_tomb && rd_tag == oaht_pkg::TAG_TOMB) begin
                        n_has_tomb = 1'b1;
                        n_tomb     = r_cur;
                    end
                    if (r_ph_home) begin
                        n_home_tag = rd_tag;
                    end
                    if (last) begin
                        n_at     = r_home;
                        n_at_tag = r_ph_home ? rd_tag : r_home_tag;
                        n_hit    = 1'b0;
                        n_state  = S_WR1;
                    end else if (r_ph_home || r_ph_down) begin
                        n_i       = inc_next;
                        n_k       = r_ph_home ? '0 : r_k + 1'b1;
                        n_up      = up_new;
                        n_cur     = SW'(up_new);
                        n_ph_home = 1'b0;
                        n_ph_down = 1'b0;
                        n_state   = S_RD;
                    end else begin
                        n_down    = down_new;
                        n_cur     = SW'(down_new);
                        n_ph_down = 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_WR1: begin
                // report a hit and tombstone it unless the action is a find
                if (r_hit) begin
                    n_found = 1'b1;
                    n_vout  = VP'(r_at_val);
                end
                if (r_hit && r_act != oaht_pkg::ACT_FIND) begin
                    wr      = '{tag_we: 1'b1, kv_we: 1'b0, tag: oaht_pkg::TAG_TOMB};
                    wr_addr = r_at;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
                if (r_act == oaht_pkg::ACT_REPLACE) begin
                    if (!r_has_tomb && eff_tag != oaht_pkg::TAG_LIVE) begin
                        n_has_tomb = 1'b1;
                        n_tomb     = r_at;
                    end
                    n_state = S_WR2;
                end else begin
                    if (r_hit) begin
                        n_sout = PP'(r_at);
                    end
                    n_state = S_OUT;
                end
            end
            S_WR2: begin
                // insert at the chosen slot, or report the table full
                if (r_has_tomb) begin
                    wr      = '{tag_we: 1'b1, kv_we: 1'b1, tag: oaht_pkg::TAG_LIVE};
                    wr_addr = r_tomb;
                    n_count = r_count + 1'b1;
                    n_sout  = PP'(r_tomb);
                end else begin
                    n_status = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
        r_act      <= n_act;
        r_key      <= n_key;
        r_val      <= n_val;
        r_slot_in  <= n_slot_in;
        r_slot_ok  <= n_slot_ok;
        r_cur      <= n_cur;
        r_home     <= n_home;
        r_up       <= n_up;
        r_down     <= n_down;
        r_i        <= n_i;
        r_k        <= n_k;
        r_ph_home  <= n_ph_home;
        r_ph_down  <= n_ph_down;
        r_has_tomb <= n_has_tomb;
        r_tomb     <= n_tomb;
        r_home_tag <= n_home_tag;
        r_at       <= n_at;
        r_at_tag   <= n_at_tag;
        r_at_val   <= n_at_val;
        r_hit      <= n_hit;
        r_found    <= n_found;
        r_vout     <= n_vout;
        r_sout     <= n_sout;
        r_status   <= n_status;
        if (out_load) begin
            r_o_found  <= r_found;
            r_o_vout   <= r_vout;
            r_o_sout   <= r_sout;
            r_o_status <= r_status;
        end
    end

    oaht_mod #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_key   (div_key),
        .i_div   (sz),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    oaht_store #(
        .SLOTS       (SLOTS),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_cur),
        .i_wr_addr  (wr_addr),
        .i_wr       (wr),
        .i_wr_key   (r_key),
        .i_wr_val   (r_val),
        .o_rd_tag   (rd_tag),
        .o_rd_key   (rd_key),
        .o_rd_val   (rd_val),
        .o_clr_done (clr_done)
    );

    assign i_req.ready     = (r_state == S_IDLE) && clr_done;
    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.found     = r_o_found;
    assign o_rsp.value_out = r_o_vout;
    assign o_rsp.slot_out  = r_o_sout;
    assign o_rsp.status    = r_o_status;

    // item count never exceeds the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= SLOTS)
        else $error("item count above store depth");

    // every probed slot lies inside the table
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && r_act != oaht_pkg::ACT_REMOVE_SLOT)
        |-> (32'(r_cur) < 32'(sz)))
        else $error("probe outside table");

    // remainder unit is idle whenever a request may be taken
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("remainder unit busy while idle");

    // sequencer never writes tags during the clear sweep
    a_no_wr_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.tag_we |-> clr_done)
        else $error("tag write during clear sweep");
endmodule
